### rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, sizes and Q16.16 saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int NX_DEFAULT      = 32;
    localparam int NNZ_MAX_DEFAULT = 256;

    localparam int ROW_W   = 6;
    localparam int SLOT_W  = 10;
    localparam int COL_W   = 6;
    localparam int RS_W    = 11;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 64;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_NZ     = 2'd0,
        MODE_RS     = 2'd1,
        MODE_SAMPLE = 2'd2,
        MODE_CALC   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_U  = 2'd0,
        REG_GAIN_V  = 2'd1,
        REG_TGT_LO  = 2'd2,
        REG_TGT_HI  = 2'd3
    } cfg_reg_t;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? Q_MIN : Q_MAX;
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? Q_MIN : Q_MAX;
        return s[DATA_W-1:0];
    endfunction

    // Product back to Q16.16: floor shift, then clamp.
    function automatic logic signed [DATA_W-1:0] q_scale(
        input logic signed [PROD_W-1:0] p
    );
        logic [PROD_W-FRAC_W-1:0] q;
        q = p[PROD_W-1:FRAC_W];
        if (q[PROD_W-FRAC_W-1:DATA_W-1] != {(PROD_W-FRAC_W-DATA_W+1){q[PROD_W-FRAC_W-1]}})
            return q[PROD_W-FRAC_W-1] ? Q_MIN : Q_MAX;
        return q[DATA_W-1:0];
    endfunction

endpackage

### rtl/csd_store.sv
// ----------------------------------------------------------------------------
// csd_store
// CSR nonzero, row start and sample memories; registered synchronous reads.
// ----------------------------------------------------------------------------
module csd_store
    import csd_pkg::*;
#(
    parameter int NX      = NX_DEFAULT,
    parameter int NNZ_MAX = NNZ_MAX_DEFAULT,
    parameter int NZ_AW   = $clog2(NNZ_MAX),
    parameter int RS_AW   = $clog2(NX + 1),
    parameter int SM_AW   = $clog2(NX)
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [1:0]               mode,
    input  logic [SLOT_W-1:0]        slot,
    input  logic [COL_W-1:0]         column,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic [RS_W-1:0]          row_start,
    input  logic signed [DATA_W-1:0] u_sample,
    input  logic signed [DATA_W-1:0] v_sample,
    input  logic [NZ_AW-1:0]         nz_rd_addr,
    input  logic [RS_AW-1:0]         rs_rd_addr,
    input  logic [SM_AW-1:0]         sm_rd_addr,
    output logic [COL_W-1:0]         nz_col,
    output logic signed [DATA_W-1:0] nz_coef,
    output logic [RS_W-1:0]          rs_data,
    output logic signed [DATA_W-1:0] sm_u,
    output logic signed [DATA_W-1:0] sm_v
);

    logic [COL_W-1:0]         col_mem  [NNZ_MAX];
    logic signed [DATA_W-1:0] coef_mem [NNZ_MAX];
    logic [RS_W-1:0]          rs_mem   [NX+1];
    logic signed [DATA_W-1:0] u_mem    [NX];
    logic signed [DATA_W-1:0] v_mem    [NX];

    logic [SLOT_W:0] slot_x;
    logic            nz_we, rs_we, sm_we;

    assign slot_x = {1'b0, slot};
    assign nz_we  = wr_en && (mode == MODE_NZ)     && (slot_x <  (SLOT_W+1)'(NNZ_MAX));
    assign rs_we  = wr_en && (mode == MODE_RS)     && (slot_x <= (SLOT_W+1)'(NX));
    assign sm_we  = wr_en && (mode == MODE_SAMPLE) && (slot_x <  (SLOT_W+1)'(NX));

    always_ff @(posedge clk)
    begin
        if (nz_we)
        begin
            col_mem[slot[NZ_AW-1:0]]  <= column;
            coef_mem[slot[NZ_AW-1:0]] <= entry_value;
        end
        nz_col  <= col_mem[nz_rd_addr];
        nz_coef <= coef_mem[nz_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[slot[RS_AW-1:0]] <= row_start;
        rs_data <= rs_mem[rs_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            u_mem[slot[SM_AW-1:0]] <= u_sample;
            v_mem[slot[SM_AW-1:0]] <= v_sample;
        end
        sm_u <= u_mem[sm_rd_addr];
        sm_v <= v_mem[sm_rd_addr];
    end

endmodule

### rtl/csd_engine.sv
// ----------------------------------------------------------------------------
// csd_engine
// Row sequencer: walks CSR rows, multiplies, accumulates, emits results.
// ----------------------------------------------------------------------------
module csd_engine
    import csd_pkg::*;
#(
    parameter int NX      = NX_DEFAULT,
    parameter int NNZ_MAX = NNZ_MAX_DEFAULT,
    parameter int NZ_AW   = $clog2(NNZ_MAX),
    parameter int RS_AW   = $clog2(NX + 1),
    parameter int SM_AW   = $clog2(NX)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic signed [DATA_W-1:0] gain_u,
    input  logic signed [DATA_W-1:0] gain_v,
    input  logic signed [DATA_W-1:0] tgt_lo,
    input  logic signed [DATA_W-1:0] tgt_hi,
    output logic [NZ_AW-1:0]         nz_rd_addr,
    output logic [RS_AW-1:0]         rs_rd_addr,
    output logic [SM_AW-1:0]         sm_rd_addr,
    input  logic [COL_W-1:0]         nz_col,
    input  logic signed [DATA_W-1:0] nz_coef,
    input  logic [RS_W-1:0]          rs_data,
    input  logic signed [DATA_W-1:0] sm_u,
    input  logic signed [DATA_W-1:0] sm_v,
    output logic                     busy,
    output logic                     res_valid,
    output logic [ROW_W-1:0]         res_row,
    output logic signed [DATA_W-1:0] res_du,
    output logic signed [DATA_W-1:0] res_dv,
    output logic                     res_last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BND_RD,
        S_BND,
        S_RS0,
        S_RS1,
        S_RS2,
        S_NZ_RD,
        S_NZ_DATA,
        S_SM_DATA,
        S_ACC,
        S_SELF,
        S_GMUL,
        S_GACC
    } state_t;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NX - 1);
    localparam logic [RS_W-1:0]  NZ_END   = RS_W'(NNZ_MAX);

    state_t                   state_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [RS_W-1:0]          k_reg;
    logic [RS_W-1:0]          end_reg;
    logic signed [DATA_W-1:0] coef_reg;
    logic signed [DATA_W-1:0] acc_u_reg, acc_v_reg;
    logic signed [DATA_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_u_reg, prod_v_reg;

    logic                     col_ok;
    logic signed [DATA_W-1:0] du_fin, dv_fin;

    assign busy       = (state_reg != S_IDLE);
    assign nz_rd_addr = k_reg[NZ_AW-1:0];
    assign rs_rd_addr = RS_AW'({1'b0, row_reg} + {{ROW_W{1'b0}}, state_reg == S_RS1});
    assign sm_rd_addr = (state_reg == S_NZ_DATA) ? nz_col[SM_AW-1:0] : row_reg[SM_AW-1:0];
    assign col_ok     = ({1'b0, nz_col} < (COL_W+1)'(NX));
    assign du_fin     = sat_add(acc_u_reg, q_scale(prod_u_reg));
    assign dv_fin     = sat_add(acc_v_reg, q_scale(prod_v_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            row_reg    <= '0;
            k_reg      <= '0;
            end_reg    <= '0;
            coef_reg   <= '0;
            acc_u_reg  <= '0;
            acc_v_reg  <= '0;
            diff_reg   <= '0;
            prod_u_reg <= '0;
            prod_v_reg <= '0;
            res_valid  <= 1'b0;
            res_row    <= '0;
            res_du     <= '0;
            res_dv     <= '0;
            res_last   <= 1'b0;
        end
        else
        begin
            res_valid <= (state_reg == S_BND) || (state_reg == S_GACC);
            unique case (state_reg)
                S_IDLE:
                begin
                    row_reg <= '0;
                    if (go)
                        state_reg <= S_BND_RD;
                end
                S_BND_RD:
                    state_reg <= S_BND;
                S_BND:
                begin
                    res_row   <= row_reg;
                    res_du    <= sat_sub((row_reg == '0) ? tgt_lo : tgt_hi, sm_u);
                    res_dv    <= '0;
                    res_last  <= (row_reg == LAST_ROW);
                    row_reg   <= row_reg + 1'b1;
                    if (row_reg == LAST_ROW)
                        state_reg <= S_IDLE;
                    else if (row_reg + 1'b1 == LAST_ROW)
                        state_reg <= S_BND_RD;
                    else
                        state_reg <= S_RS0;
                end
                S_RS0:
                begin
                    acc_u_reg <= '0;
                    acc_v_reg <= '0;
                    state_reg <= S_RS1;
                end
                S_RS1:
                begin
                    k_reg     <= rs_data;
                    state_reg <= S_RS2;
                end
                S_RS2:
                begin
                    end_reg   <= (rs_data > NZ_END) ? NZ_END : rs_data;
                    state_reg <= S_NZ_RD;
                end
                S_NZ_RD:
                    state_reg <= (k_reg < end_reg) ? S_NZ_DATA : S_SELF;
                S_NZ_DATA:
                begin
                    coef_reg <= nz_coef;
                    if (col_ok)
                        state_reg <= S_SM_DATA;
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_NZ_RD;
                    end
                end
                S_SM_DATA:
                begin
                    prod_u_reg <= coef_reg * sm_u;
                    prod_v_reg <= coef_reg * sm_v;
                    state_reg  <= S_ACC;
                end
                S_ACC:
                begin
                    acc_u_reg <= du_fin;
                    acc_v_reg <= dv_fin;
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= S_NZ_RD;
                end
                S_SELF:
                begin
                    diff_reg  <= sat_sub(sm_u, sm_v);
                    state_reg <= S_GMUL;
                end
                S_GMUL:
                begin
                    prod_u_reg <= gain_u * diff_reg;
                    prod_v_reg <= gain_v * diff_reg;
                    state_reg  <= S_GACC;
                end
                S_GACC:
                begin
                    res_row   <= row_reg;
                    res_du    <= du_fin;
                    res_dv    <= dv_fin;
                    res_last  <= 1'b0;
                    row_reg   <= row_reg + 1'b1;
                    state_reg <= (row_reg + 1'b1 == LAST_ROW) ? S_BND_RD : S_RS0;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/csr_spmv_coupled_derivative_top.sv
// ----------------------------------------------------------------------------
// csr_spmv_coupled_derivative_top
// Coupled two-field CSR sparse matrix-vector derivative engine.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers on a clock edge with start high and
//   busy low. Modes 0..2 load a CSR nonzero, a row start pointer or a u/v
//   sample pair; they take effect at that edge and busy never rises.
//   Mode 3 runs a compute pass: busy stays high until the last row is out.
//   Results: result_valid strobes for one cycle per row, rows 0..NX-1 in
//   order, last marking row NX-1. The receiver cannot stall; every strobe
//   is a transfer.
//   Config channel: cfg_ready is always high; write only while idle.
// Sequencing:
//   A boundary row makes one sample read. An inner row reads its two row start
//   pointers, steps through its nonzeros (those with column >= NX are skipped),
//   then adds the gain term; the order follows the single read port of each
//   store and the read -> multiply -> accumulate sequence per nonzero.
// Reset:
//   rst_n clears the sequencer and the config registers; store contents are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module csr_spmv_coupled_derivative_top
    import csd_pkg::*;
#(
    parameter int NX      = NX_DEFAULT,
    parameter int NNZ_MAX = NNZ_MAX_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  mode,
    input  logic [SLOT_W-1:0]           slot,
    input  logic [COL_W-1:0]            column,
    input  logic signed [DATA_W-1:0]    entry_value,
    input  logic [RS_W-1:0]             row_start,
    input  logic signed [DATA_W-1:0]    u_sample,
    input  logic signed [DATA_W-1:0]    v_sample,
    output logic                        result_valid,
    output logic [ROW_W-1:0]            row,
    output logic signed [DATA_W-1:0]    du,
    output logic signed [DATA_W-1:0]    dv,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data
);

    localparam int NZ_AW = $clog2(NNZ_MAX);
    localparam int RS_AW = $clog2(NX + 1);
    localparam int SM_AW = $clog2(NX);

    logic signed [DATA_W-1:0] gain_u_reg, gain_v_reg, tgt_lo_reg, tgt_hi_reg;

    logic                     accept;
    logic                     go;
    logic [NZ_AW-1:0]         nz_rd_addr;
    logic [RS_AW-1:0]         rs_rd_addr;
    logic [SM_AW-1:0]         sm_rd_addr;
    logic [COL_W-1:0]         nz_col;
    logic signed [DATA_W-1:0] nz_coef;
    logic [RS_W-1:0]          rs_data;
    logic signed [DATA_W-1:0] sm_u, sm_v;

    // Command transfer; only compute items start the sequencer.
    assign accept    = start && !busy;
    assign go        = accept && (mode == MODE_CALC);
    assign cfg_ready = 1'b1;

    // Config registers, Q16.16 each.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_u_reg <= '0;
            gain_v_reg <= '0;
            tgt_lo_reg <= '0;
            tgt_hi_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN_U: gain_u_reg <= cfg_data;
                REG_GAIN_V: gain_v_reg <= cfg_data;
                REG_TGT_LO: tgt_lo_reg <= cfg_data;
                REG_TGT_HI: tgt_hi_reg <= cfg_data;
                default:    gain_u_reg <= gain_u_reg;
            endcase
        end
    end

    csd_store #(
        .NX      (NX),
        .NNZ_MAX (NNZ_MAX),
        .NZ_AW   (NZ_AW),
        .RS_AW   (RS_AW),
        .SM_AW   (SM_AW)
    ) u_store (
        .clk         (clk),
        .wr_en       (accept),
        .mode        (mode),
        .slot        (slot),
        .column      (column),
        .entry_value (entry_value),
        .row_start   (row_start),
        .u_sample    (u_sample),
        .v_sample    (v_sample),
        .nz_rd_addr  (nz_rd_addr),
        .rs_rd_addr  (rs_rd_addr),
        .sm_rd_addr  (sm_rd_addr),
        .nz_col      (nz_col),
        .nz_coef     (nz_coef),
        .rs_data     (rs_data),
        .sm_u        (sm_u),
        .sm_v        (sm_v)
    );

    csd_engine #(
        .NX      (NX),
        .NNZ_MAX (NNZ_MAX),
        .NZ_AW   (NZ_AW),
        .RS_AW   (RS_AW),
        .SM_AW   (SM_AW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .gain_u     (gain_u_reg),
        .gain_v     (gain_v_reg),
        .tgt_lo     (tgt_lo_reg),
        .tgt_hi     (tgt_hi_reg),
        .nz_rd_addr (nz_rd_addr),
        .rs_rd_addr (rs_rd_addr),
        .sm_rd_addr (sm_rd_addr),
        .nz_col     (nz_col),
        .nz_coef    (nz_coef),
        .rs_data    (rs_data),
        .sm_u       (sm_u),
        .sm_v       (sm_v),
        .busy       (busy),
        .res_valid  (result_valid),
        .res_row    (row),
        .res_du     (du),
        .res_dv     (dv),
        .res_last   (last)
    );

endmodule

### verif/csd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_checker
// Follows the command, config and result channels, keeps its own copy of the
// stores and registers, predicts each row pair of a compute pass and compares.
// ----------------------------------------------------------------------------
module csd_checker
    import csd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [1:0]               mode,
    input  logic [SLOT_W-1:0]        slot,
    input  logic [COL_W-1:0]         column,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic [RS_W-1:0]          row_start,
    input  logic signed [DATA_W-1:0] u_sample,
    input  logic signed [DATA_W-1:0] v_sample,
    input  logic                     result_valid,
    input  logic [ROW_W-1:0]         row,
    input  logic signed [DATA_W-1:0] du,
    input  logic signed [DATA_W-1:0] dv,
    input  logic                     last,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    output int                       fail_count,
    output int                       pending
);
    localparam int NX    = NX_DEFAULT;
    localparam int NNZ   = NNZ_MAX_DEFAULT;
    localparam int NZ_AW = $clog2(NNZ);
    localparam int RS_AW = $clog2(NX + 1);
    localparam int SM_AW = $clog2(NX);

    typedef struct {
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] du;
        logic signed [DATA_W-1:0] dv;
        logic                     last;
    } deriv_t;

    logic signed [DATA_W-1:0] gain_u, gain_v, tgt_lo, tgt_hi;
    logic [RS_W-1:0]          rs_mem [0:NX];
    logic [COL_W-1:0]         col_mem [0:NNZ-1];
    logic signed [DATA_W-1:0] coef_mem [0:NNZ-1];
    logic signed [DATA_W-1:0] u_mem [0:NX-1];
    logic signed [DATA_W-1:0] v_mem [0:NX-1];

    deriv_t expected_rows[$];
    int     mismatches;

    assign fail_count = mismatches;
    assign pending    = expected_rows.size();

    function automatic logic signed [DATA_W-1:0] clamp(input longint x);
        if (x > 64'sd2147483647)
            return Q_MAX;
        if (x < -64'sd2147483648)
            return Q_MIN;
        return x[DATA_W-1:0];
    endfunction

    // floor shift of the exact product
    function automatic logic signed [DATA_W-1:0] qmul(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        longint p;
        p = longint'(a) * longint'(b);
        return clamp(p >>> FRAC_W);
    endfunction

    function automatic logic signed [DATA_W-1:0] qadd(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return clamp(longint'(a) + longint'(b));
    endfunction

    task automatic predict_pass();
        deriv_t                   r;
        int                       k, stop;
        logic signed [DATA_W-1:0] acc_u, acc_v, diff;
        for (int i = 0; i < NX; i++) begin
            acc_u = '0;
            acc_v = '0;
            if (i == 0) begin
                acc_u = clamp(longint'(tgt_lo) - longint'(u_mem[0]));
            end
            else if (i == NX - 1) begin
                acc_u = clamp(longint'(tgt_hi) - longint'(u_mem[NX-1]));
            end
            else begin
                stop = (int'(rs_mem[i+1]) > NNZ) ? NNZ : int'(rs_mem[i+1]);
                for (k = int'(rs_mem[i]); k < stop; k++) begin
                    if (col_mem[k] < NX) begin
                        acc_u = qadd(acc_u, qmul(coef_mem[k], u_mem[col_mem[k][SM_AW-1:0]]));
                        acc_v = qadd(acc_v, qmul(coef_mem[k], v_mem[col_mem[k][SM_AW-1:0]]));
                    end
                end
                diff  = clamp(longint'(u_mem[i]) - longint'(v_mem[i]));
                acc_u = qadd(acc_u, qmul(gain_u, diff));
                acc_v = qadd(acc_v, qmul(gain_v, diff));
            end
            r.row  = i[ROW_W-1:0];
            r.du   = acc_u;
            r.dv   = acc_v;
            r.last = (i == NX - 1);
            expected_rows.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        deriv_t want;
        if (!rst_n) begin
            gain_u = '0;
            gain_v = '0;
            tgt_lo = '0;
            tgt_hi = '0;
            expected_rows.delete();
            mismatches = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_GAIN_U: gain_u = cfg_data;
                    REG_GAIN_V: gain_v = cfg_data;
                    REG_TGT_LO: tgt_lo = cfg_data;
                    REG_TGT_HI: tgt_hi = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid) begin
                if (expected_rows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: row %0d du %h dv %h with nothing expected",
                                 row, du, dv);
                end
                else begin
                    want = expected_rows.pop_front();
                    if (want.row !== row || want.du !== du || want.dv !== dv
                        || want.last !== last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp row %0d du %h dv %h last %b, got row %0d du %h dv %h last %b",
                                     want.row, want.du, want.dv, want.last,
                                     row, du, dv, last);
                    end
                end
            end
            if (start && !busy) begin
                case (mode_t'(mode))
                    MODE_NZ:
                        if (slot < NNZ) begin
                            col_mem[slot[NZ_AW-1:0]]  = column;
                            coef_mem[slot[NZ_AW-1:0]] = entry_value;
                        end
                    MODE_RS:
                        if (slot <= NX)
                            rs_mem[slot[RS_AW-1:0]] = row_start;
                    MODE_SAMPLE:
                        if (slot < NX) begin
                            u_mem[slot[SM_AW-1:0]] = u_sample;
                            v_mem[slot[SM_AW-1:0]] = v_sample;
                        end
                    default:
                        predict_pass();
                endcase
            end
        end
    end
endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the coupled CSR derivative engine: loads every
// store entry that a compute pass reads, runs directed then random
// load/compute traffic over several gain and target settings; the checker
// does prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import csd_pkg::*;

    localparam int NX       = NX_DEFAULT;
    localparam int NNZ      = NNZ_MAX_DEFAULT;
    // row spans stay in the top slots of the nonzero store
    localparam int NZ_BASE  = NNZ - 8;
    localparam int WD_LIMIT = 2000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               mode;
    logic [SLOT_W-1:0]        slot;
    logic [COL_W-1:0]         column;
    logic signed [DATA_W-1:0] entry_value;
    logic [RS_W-1:0]          row_start;
    logic signed [DATA_W-1:0] u_sample;
    logic signed [DATA_W-1:0] v_sample;
    logic                     result_valid;
    logic [ROW_W-1:0]         row;
    logic signed [DATA_W-1:0] du;
    logic signed [DATA_W-1:0] dv;
    logic                     last;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    int                       fail_count;
    int                       pending;
    int                       idle_cycles;
    bit                       gaps_on;

    csr_spmv_coupled_derivative_top u_dut (.*);

    csd_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any transfer on any channel resets the count.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Q16.16 value biased toward the saturation corners.
    function automatic logic [DATA_W-1:0] pick_q();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            default: return $urandom;
        endcase
    endfunction

    // One command transfer, then the sender's own gap.
    task automatic send(input mode_t m, input int s, input int c,
                        input logic [DATA_W-1:0] e, input int r,
                        input logic [DATA_W-1:0] uu, input logic [DATA_W-1:0] vv);
        int gap;
        start       <= 1'b1;
        mode        <= m;
        slot        <= SLOT_W'(s);
        column      <= COL_W'(c);
        entry_value <= e;
        row_start   <= RS_W'(r);
        u_sample    <= uu;
        v_sample    <= vv;
        do
            @(posedge clk);
        while (busy);
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_nz(input int s, input int c, input logic [DATA_W-1:0] e);
        send(MODE_NZ, s, c, e, $urandom_range(0, 2047), $urandom, $urandom);
    endtask

    task automatic send_rs(input int s, input int r);
        send(MODE_RS, s, $urandom_range(0, 63), $urandom, r, $urandom, $urandom);
    endtask

    task automatic send_pair(input int s, input logic [DATA_W-1:0] uu,
                             input logic [DATA_W-1:0] vv);
        send(MODE_SAMPLE, s, $urandom_range(0, 63), $urandom,
             $urandom_range(0, 2047), uu, vv);
    endtask

    task automatic send_calc();
        send(MODE_CALC, $urandom_range(0, 1023), $urandom_range(0, 63), $urandom,
             $urandom_range(0, 2047), $urandom, $urandom);
    endtask

    // Block idle: all rows back, plus margin for a trailing load.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int s;
        int r;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:
                send_nz(($urandom_range(0, 9) == 0) ? $urandom_range(NNZ, 1023)
                                                    : $urandom_range(0, NNZ - 1),
                        $urandom_range(0, 63), pick_q());
            6, 7, 8, 9:
            begin
                s = ($urandom_range(0, 9) == 0) ? $urandom_range(NX + 1, 1023)
                                                : $urandom_range(0, NX);
                // rows that compute reads start in the loaded top slots;
                // a few ends run past the store
                if (s >= 1 && s <= NX - 1)
                    r = ($urandom_range(0, 4) == 0) ? $urandom_range(NNZ + 1, 2047)
                                                    : $urandom_range(NZ_BASE, NNZ);
                else
                    r = $urandom_range(0, 2047);
                send_rs(s, r);
            end
            10, 11, 12, 13, 14, 15, 16:
                send_pair(($urandom_range(0, 9) == 0) ? $urandom_range(NX, 1023)
                                                      : $urandom_range(0, NX - 1),
                          pick_q(), pick_q());
            default:
                send_calc();
        endcase
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_NZ;
        slot        = '0;
        column      = '0;
        entry_value = '0;
        row_start   = '0;
        u_sample    = '0;
        v_sample    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_GAIN_U;
        cfg_data    = '0;
        gaps_on     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every entry a compute reads: top nonzero slots, inner row
        // starts pointing into them, and all samples.
        for (int k = NZ_BASE; k < NNZ; k++)
            send_nz(k, $urandom_range(0, 63), pick_q());
        for (int k = 1; k < NX; k++)
            send_rs(k, NZ_BASE + (k * 3) % 9);
        for (int k = 0; k < NX; k++)
            send_pair(k, pick_q(), pick_q());

        // Directed: extremes, ignored slots, spans past the store, all modes.
        gaps_on = 1'b1;
        send_pair(0, Q_MAX, Q_MIN);
        send_pair(NX - 1, Q_MIN, Q_MAX);
        send_pair(1, Q_MAX, Q_MIN);
        send_pair(2, Q_MIN, Q_MAX);
        send_nz(NZ_BASE, 1, Q_MAX);
        send_nz(NZ_BASE + 1, 63, Q_MAX);
        send_nz(1023, 0, 32'h0001_0000);
        send_rs(1023, 5);
        send_pair(NX, Q_MIN, Q_MIN);
        send_rs(1, NZ_BASE);
        send_rs(2, 1024);
        send_rs(29, 2047);
        send_calc();
        drain();
        write_reg(REG_GAIN_U, Q_MAX);
        write_reg(REG_GAIN_V, Q_MIN);
        write_reg(REG_TGT_LO, Q_MIN);
        write_reg(REG_TGT_HI, Q_MAX);
        send_calc();
        send_rs(29, NZ_BASE + 2);
        send_calc();
        drain();

        // Random phases over several register settings; each phase drains.
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_GAIN_U, (ph == 0) ? Q_MIN : pick_q());
            write_reg(REG_GAIN_V, (ph == 0) ? Q_MAX : pick_q());
            write_reg(REG_TGT_LO, (ph == 1) ? '0 : pick_q());
            write_reg(REG_TGT_HI, (ph == 1) ? '0 : pick_q());
            gaps_on = (ph != 2);
            for (int n = 0; n < 5; n++)
                random_item();
            send_calc();
            drain();
        end

        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
